// File: hdl/tsme_pkg.sv
// shared types, constants and helpers of the typed stack machine executor
// used by the top level and by its port checker; depends on nothing else
package tsme_pkg;

	localparam int STACK_DEPTH = 256;
	localparam int ADDR_W = $clog2(STACK_DEPTH);
	localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
	localparam int NUM_W = 32;
	localparam int SLOT_W = NUM_W + 2;
	localparam int DIV_STEPS = NUM_W + 16;
	localparam int DCNT_W = $clog2(DIV_STEPS);
	localparam int TAG_BIT = NUM_W + 1;
	localparam int BOOL_BIT = NUM_W;

	typedef logic [SLOT_W-1:0] slot_t;

	typedef enum logic [4:0] {
		CMD_START  = 5'd0,
		CMD_CONST  = 5'd1,
		CMD_POP    = 5'd2,
		CMD_NEG    = 5'd3,
		CMD_ADD    = 5'd4,
		CMD_SUB    = 5'd5,
		CMD_MUL    = 5'd6,
		CMD_DIV    = 5'd7,
		CMD_NOT    = 5'd8,
		CMD_AND    = 5'd9,
		CMD_OR     = 5'd10,
		CMD_ASSIGN = 5'd11,
		CMD_EQ     = 5'd12,
		CMD_NE     = 5'd13,
		CMD_GT     = 5'd14,
		CMD_GE     = 5'd15,
		CMD_LT     = 5'd16,
		CMD_LE     = 5'd17,
		CMD_RETURN = 5'd18
	} cmd_t;

	typedef enum logic [3:0] {
		ST_RUNNING     = 4'd0,
		ST_OK          = 4'd1,
		ST_PRINT       = 4'd2,
		ST_TYPE_ERR    = 4'd3,
		ST_DIV_ZERO    = 4'd4,
		ST_UNKNOWN_OP  = 4'd5,
		ST_ASSIGN      = 4'd6,
		ST_STACK_FAULT = 4'd7,
		ST_IGNORED     = 4'd8
	} status_t;

	// everything one instruction changes, applied together at its commit
	typedef struct packed {
		status_t             status;
		slot_t               value;
		logic                we;
		logic [ADDR_W-1:0]   waddr;
		slot_t               wdata;
		logic [DEPTH_W-1:0]  depth;
		logic                run;
		logic                start;
	} commit_t;

	function automatic slot_t make_bool(input logic b);
		return {1'b1, b, {NUM_W{1'b0}}};
	endfunction

	function automatic logic same_slot(input slot_t a, input slot_t b);
		logic r;
		if (a[TAG_BIT] != b[TAG_BIT])
			r = 1'b0;
		else if (a[TAG_BIT])
			r = (a[BOOL_BIT] == b[BOOL_BIT]);
		else
			r = (a[NUM_W-1:0] == b[NUM_W-1:0]);
		return r;
	endfunction

	// signed 33-bit sum to 32 bits with saturation
	function automatic logic [NUM_W-1:0] sat33(input logic [NUM_W:0] v);
		logic [NUM_W-1:0] r;
		if (v[NUM_W] != v[NUM_W-1])
			r = v[NUM_W] ? {1'b1, {(NUM_W-1){1'b0}}} : {1'b0, {(NUM_W-1){1'b1}}};
		else
			r = v[NUM_W-1:0];
		return r;
	endfunction

	// magnitude plus sign to saturated two's complement
	function automatic logic [NUM_W-1:0] sat_mag(input logic [DIV_STEPS:0] m, input logic neg);
		logic [DIV_STEPS:0] lim;
		logic [DIV_STEPS:0] c;
		lim = neg ? (DIV_STEPS+1)'(64'h8000_0000) : (DIV_STEPS+1)'(64'h7FFF_FFFF);
		c = (m > lim) ? lim : m;
		return neg ? (NUM_W'(0) - c[NUM_W-1:0]) : c[NUM_W-1:0];
	endfunction

endpackage

// File: hdl/typed_stack_machine_executor_top.sv
// top level of the typed stack machine executor: stack memory, decode, alu, divider
// depends on tsme_pkg
// One result word per input word. For a plain instruction the accept cycle issues both
// operand reads to the stack memory (registered read) and the next cycle executes; the
// result is applied to the stack once the output register is free, and the next word can
// be accepted in that same cycle, with forwarding from that write to the new reads.
// Multiply passes through S_MULF for the rounding and saturation after the 32x32 product.
// Divide runs a restoring divider one quotient bit per cycle, 48 steps plus one for
// rounding. A new word is taken while an earlier result still sits in the output register;
// a stall on the output holds the following instruction before it touches the stack.
module typed_stack_machine_executor_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [4:0]  cmd,
	input  logic        const_is_bool,
	input  logic signed [31:0] const_number,
	input  logic        const_bool,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  status,
	output logic        value_is_bool,
	output logic signed [31:0] slot_number,
	output logic        slot_bool
);

	localparam int AW = tsme_pkg::ADDR_W;
	localparam int DW = tsme_pkg::DEPTH_W;
	localparam int NW = tsme_pkg::NUM_W;
	localparam int QW = tsme_pkg::DIV_STEPS;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_EXEC = 6'b000010,
		S_MULF = 6'b000100,
		S_DIVI = 6'b001000,
		S_DIVF = 6'b010000,
		S_WAIT = 6'b100000
	} state_t;

	state_t state_q;

	tsme_pkg::slot_t mem [tsme_pkg::STACK_DEPTH];
	tsme_pkg::slot_t rd_a_q, rd_b_q, fwd_data_q, bottom_q, saved_q;
	logic fwd_a_q, fwd_b_q;

	logic [4:0]      cmd_q;
	logic            cib_q, cb_q;
	logic [NW-1:0]   cnum_q;
	logic [DW-1:0]   depth_q;
	logic            run_q;
	tsme_pkg::commit_t pend_q, c;

	logic [2*NW-1:0] prod_q;
	logic            neg_q;
	logic [NW-1:0]   rem_q, den_q;
	logic [QW-1:0]   num_q, quo_q;
	logic [tsme_pkg::DCNT_W-1:0] cnt_q;

	logic out_free, commit, in_acc;
	logic [DW-1:0] dsrc;
	logic [AW-1:0] ra, rb;

	// execute stage signals
	tsme_pkg::slot_t opa, opb, op1, r;
	logic [1:0]      need;
	logic [NW-1:0]   x, y, magx, magy;
	logic            neg, go_mul, go_div, wr;
	tsme_pkg::status_t st;
	logic [DW-1:0]   dm;

	// divider step
	logic [NW:0]     dsh;
	logic            dge;
	logic [QW:0]     q_rnd, m_rnd;

	assign out_free = !out_valid || out_ready;
	assign commit   = (state_q == S_WAIT) && out_free;
	assign in_ready = (state_q == S_IDLE) || commit;
	assign in_acc   = in_valid && in_ready;

	// read addresses come from the depth after any commit in the same cycle
	assign dsrc = (state_q == S_WAIT) ? pend_q.depth : depth_q;
	assign ra   = AW'(dsrc - DW'(2));
	assign rb   = AW'(dsrc - DW'(1));

	always_ff @(posedge clk) begin
		if (commit && pend_q.we)
			mem[pend_q.waddr] <= pend_q.wdata;
		if (in_acc) begin
			rd_a_q <= mem[ra];
			rd_b_q <= mem[rb];
		end
	end

	// execute
	always_comb begin
		opa = fwd_a_q ? fwd_data_q : rd_a_q;
		opb = fwd_b_q ? fwd_data_q : rd_b_q;
		need = 2'd0;
		unique case (cmd_q)
			tsme_pkg::CMD_POP, tsme_pkg::CMD_NEG, tsme_pkg::CMD_NOT: need = 2'd1;
			tsme_pkg::CMD_ADD, tsme_pkg::CMD_SUB, tsme_pkg::CMD_MUL, tsme_pkg::CMD_DIV,
			tsme_pkg::CMD_AND, tsme_pkg::CMD_OR, tsme_pkg::CMD_EQ, tsme_pkg::CMD_NE,
			tsme_pkg::CMD_GT, tsme_pkg::CMD_GE, tsme_pkg::CMD_LT,
			tsme_pkg::CMD_LE: need = 2'd2;
			default: need = 2'd0;
		endcase
		op1  = (need == 2'd1) ? opb : opa;
		x    = op1[NW-1:0];
		y    = opb[NW-1:0];
		magx = x[NW-1] ? (NW'(0) - x) : x;
		magy = y[NW-1] ? (NW'(0) - y) : y;
		neg  = x[NW-1] ^ y[NW-1];
		dm   = depth_q - DW'(need);
		st   = tsme_pkg::ST_RUNNING;
		r    = '0;
		wr   = 1'b0;
		go_mul = 1'b0;
		go_div = 1'b0;
		c = '0;
		c.depth = depth_q;
		if (cmd_q == tsme_pkg::CMD_START) begin
			c.start = 1'b1;
			c.depth = '0;
		end else if (!run_q) begin
			st = tsme_pkg::ST_IGNORED;
		end else begin
			unique case (cmd_q)
				tsme_pkg::CMD_CONST: begin
					if (depth_q == DW'(tsme_pkg::STACK_DEPTH))
						st = tsme_pkg::ST_STACK_FAULT;
					else begin
						c.we = 1'b1;
						c.waddr = AW'(depth_q);
						c.wdata = cib_q ? tsme_pkg::make_bool(cb_q) : {2'b00, cnum_q};
						c.depth = depth_q + DW'(1);
					end
				end
				tsme_pkg::CMD_RETURN: begin
					st = tsme_pkg::same_slot(saved_q, bottom_q) ? tsme_pkg::ST_OK :
						tsme_pkg::ST_PRINT;
					c.value = bottom_q;
				end
				tsme_pkg::CMD_ASSIGN: st = tsme_pkg::ST_ASSIGN;
				tsme_pkg::CMD_POP: begin
					if (depth_q < DW'(need))
						st = tsme_pkg::ST_STACK_FAULT;
					else
						c.depth = dm;
				end
				tsme_pkg::CMD_NEG, tsme_pkg::CMD_NOT, tsme_pkg::CMD_AND, tsme_pkg::CMD_OR,
				tsme_pkg::CMD_EQ, tsme_pkg::CMD_NE: begin
					if (depth_q < DW'(need))
						st = tsme_pkg::ST_STACK_FAULT;
					else begin
						wr = 1'b1;
						case (cmd_q)
							tsme_pkg::CMD_NEG: begin
								if (op1[tsme_pkg::TAG_BIT])
									st = tsme_pkg::ST_TYPE_ERR;
								else
									r = {2'b00, tsme_pkg::sat33((NW+1)'(0) - {x[NW-1], x})};
							end
							tsme_pkg::CMD_NOT: begin
								if (!op1[tsme_pkg::TAG_BIT])
									st = tsme_pkg::ST_TYPE_ERR;
								else
									r = tsme_pkg::make_bool(!op1[tsme_pkg::BOOL_BIT]);
							end
							tsme_pkg::CMD_AND, tsme_pkg::CMD_OR: begin
								if (!opa[tsme_pkg::TAG_BIT] || !opb[tsme_pkg::TAG_BIT])
									st = tsme_pkg::ST_TYPE_ERR;
								else if (cmd_q == tsme_pkg::CMD_AND)
									r = tsme_pkg::make_bool(opa[tsme_pkg::BOOL_BIT] &&
										opb[tsme_pkg::BOOL_BIT]);
								else
									r = tsme_pkg::make_bool(opa[tsme_pkg::BOOL_BIT] ||
										opb[tsme_pkg::BOOL_BIT]);
							end
							default: begin
								if (opa[tsme_pkg::TAG_BIT] != opb[tsme_pkg::TAG_BIT])
									st = tsme_pkg::ST_TYPE_ERR;
								else
									r = tsme_pkg::make_bool(tsme_pkg::same_slot(opa, opb) ==
										(cmd_q == tsme_pkg::CMD_EQ));
							end
						endcase
					end
				end
				tsme_pkg::CMD_ADD, tsme_pkg::CMD_SUB, tsme_pkg::CMD_MUL, tsme_pkg::CMD_DIV,
				tsme_pkg::CMD_GT, tsme_pkg::CMD_GE, tsme_pkg::CMD_LT, tsme_pkg::CMD_LE: begin
					if (depth_q < DW'(need))
						st = tsme_pkg::ST_STACK_FAULT;
					else if (opa[tsme_pkg::TAG_BIT] || opb[tsme_pkg::TAG_BIT])
						st = tsme_pkg::ST_TYPE_ERR;
					else begin
						wr = 1'b1;
						case (cmd_q)
							tsme_pkg::CMD_ADD:
								r = {2'b00, tsme_pkg::sat33({x[NW-1], x} + {y[NW-1], y})};
							tsme_pkg::CMD_SUB:
								r = {2'b00, tsme_pkg::sat33({x[NW-1], x} - {y[NW-1], y})};
							tsme_pkg::CMD_MUL: go_mul = 1'b1;
							tsme_pkg::CMD_DIV: begin
								if (y == '0)
									st = tsme_pkg::ST_DIV_ZERO;
								else
									go_div = 1'b1;
							end
							tsme_pkg::CMD_GT: r = tsme_pkg::make_bool($signed(x) > $signed(y));
							tsme_pkg::CMD_GE: r = tsme_pkg::make_bool($signed(x) >= $signed(y));
							tsme_pkg::CMD_LT: r = tsme_pkg::make_bool($signed(x) < $signed(y));
							default: r = tsme_pkg::make_bool($signed(x) <= $signed(y));
						endcase
					end
				end
				default: st = tsme_pkg::ST_UNKNOWN_OP;
			endcase
			if (wr && st == tsme_pkg::ST_RUNNING) begin
				c.we = 1'b1;
				c.waddr = AW'(dm);
				c.wdata = r;
				c.depth = dm + DW'(1);
			end
		end
		c.status = st;
		c.run = c.start || (run_q && st == tsme_pkg::ST_RUNNING);
	end

	// restoring divider step and final rounding
	assign dsh   = {rem_q, num_q[QW-1]};
	assign dge   = dsh >= {1'b0, den_q};
	assign q_rnd = {1'b0, quo_q} + (QW+1)'({rem_q, 1'b0} >= {1'b0, den_q});
	assign m_rnd = (QW+1)'((prod_q + (2*NW)'(32'h8000)) >> 16);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			depth_q   <= '0;
			run_q     <= 1'b0;
			bottom_q  <= '0;
			saved_q   <= '0;
			out_valid <= 1'b0;
			fwd_a_q   <= 1'b0;
			fwd_b_q   <= 1'b0;
		end else begin
			if (commit) begin
				depth_q <= pend_q.depth;
				run_q   <= pend_q.run;
				if (pend_q.start)
					saved_q <= bottom_q;
				if (pend_q.we && pend_q.waddr == '0)
					bottom_q <= pend_q.wdata;
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			if (in_acc) begin
				fwd_a_q <= commit && pend_q.we && pend_q.waddr == ra;
				fwd_b_q <= commit && pend_q.we && pend_q.waddr == rb;
			end
			unique case (state_q)
				S_IDLE: if (in_acc) state_q <= S_EXEC;
				S_EXEC: begin
					if (go_mul)
						state_q <= S_MULF;
					else if (go_div)
						state_q <= S_DIVI;
					else
						state_q <= S_WAIT;
				end
				S_MULF: state_q <= S_WAIT;
				S_DIVI: if (cnt_q == tsme_pkg::DCNT_W'(QW - 1)) state_q <= S_DIVF;
				S_DIVF: state_q <= S_WAIT;
				S_WAIT: begin
					if (in_acc)
						state_q <= S_EXEC;
					else if (commit)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q  <= cmd;
			cib_q  <= const_is_bool;
			cnum_q <= const_number;
			cb_q   <= const_bool;
		end
		if (commit) begin
			fwd_data_q    <= pend_q.wdata;
			status        <= pend_q.status;
			value_is_bool <= pend_q.value[tsme_pkg::TAG_BIT];
			slot_bool     <= pend_q.value[tsme_pkg::BOOL_BIT];
			slot_number   <= pend_q.value[NW-1:0];
		end
		if (state_q == S_EXEC) begin
			pend_q <= c;
			prod_q <= magx * magy;
			neg_q  <= neg;
			rem_q  <= '0;
			num_q  <= {magx, 16'd0};
			den_q  <= magy;
			quo_q  <= '0;
			cnt_q  <= '0;
		end
		if (state_q == S_MULF)
			pend_q.wdata <= {2'b00, tsme_pkg::sat_mag(m_rnd, neg_q)};
		if (state_q == S_DIVI) begin
			rem_q <= dge ? NW'(dsh - {1'b0, den_q}) : NW'(dsh);
			num_q <= {num_q[QW-2:0], 1'b0};
			quo_q <= {quo_q[QW-2:0], dge};
			cnt_q <= cnt_q + tsme_pkg::DCNT_W'(1);
		end
		if (state_q == S_DIVF)
			pend_q.wdata <= {2'b00, tsme_pkg::sat_mag(q_rnd, neg_q)};
	end

endmodule

// File: hdl/tsme_checker.sv
// port-level checker for the typed stack machine executor, bound to the top level
// depends on tsme_pkg
module tsme_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [4:0]  cmd,
	input logic        const_is_bool,
	input logic [31:0] const_number,
	input logic        const_bool,
	input logic        out_valid,
	input logic        out_ready,
	input logic [3:0]  status,
	input logic        value_is_bool,
	input logic [31:0] slot_number,
	input logic        slot_bool
);

	// an offered input word holds still until taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(cmd) && $stable(const_is_bool) &&
		$stable(const_number) && $stable(const_bool))
		else $error("input word changed while stalled");

	// a result word waiting on the output keeps its status and slot number
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(slot_number))
		else $error("output word changed while stalled");

	// only a return carries a slot
	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != tsme_pkg::ST_OK && status != tsme_pkg::ST_PRINT |->
		slot_number == '0 && !value_is_bool && !slot_bool)
		else $error("non-return word carries a value");

	// a number slot never has its bool bit set
	a_num_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !value_is_bool |-> !slot_bool)
		else $error("number slot with bool bit");

	// a bool slot never has number bits
	a_bool_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && value_is_bool |-> slot_number == '0)
		else $error("bool slot with number bits");

endmodule

bind typed_stack_machine_executor_top tsme_checker u_tsme_checker (.*);
